[rtl/ldc_pkg.sv]
// ----------------------------------------------------------------------------
// LRU descriptor cache package
// Shared widths, codes and the structs that run along the chain of cells.
// ----------------------------------------------------------------------------
package ldc_pkg;

  localparam int KEY_W            = 31;
  localparam int HANDLE_W         = 16;
  localparam int CMD_W            = 2;
  localparam int COUNT_OUT_W      = 7;
  localparam int DEFAULT_CAPACITY = 64;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOOKUP = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_CLEAR  = 2'd2,
    CMD_NOP    = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_PROMOTE,
    OP_PROMOTE_SET,
    OP_EVICT,
    OP_FILL,
    OP_CLEAR
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE
  } state_t;

  typedef struct packed {
    logic                found;
    logic [HANDLE_W-1:0] found_handle;
    logic                lru_found;
    logic [KEY_W-1:0]    lru_key;
    logic [HANDLE_W-1:0] lru_handle;
    logic                free_seen;
  } carry_t;

  typedef struct packed {
    op_t                 op;
    logic [KEY_W-1:0]    key;
    logic [HANDLE_W-1:0] handle;
  } upd_t;

endpackage

[rtl/ldc_cell.sv]
// ----------------------------------------------------------------------------
// LRU descriptor cache cell
// Holds one entry and its recency rank, folds its entry into the search
// record passed down the chain, and applies the broadcast table update.
// ----------------------------------------------------------------------------
module ldc_cell
  import ldc_pkg::*;
#(
  parameter int RANK_W = 6
) (
  input  logic              clk,
  input  logic              rst,
  input  upd_t              upd,
  input  logic [RANK_W-1:0] pivot_rank,
  input  logic [RANK_W-1:0] new_rank,
  input  carry_t            carry_in,
  input  logic [RANK_W-1:0] rank_in,
  output carry_t            carry_out,
  output logic [RANK_W-1:0] rank_out
);

  logic                valid;
  logic [RANK_W-1:0]   rank;
  logic [KEY_W-1:0]    key;
  logic [HANDLE_W-1:0] handle;

  logic   match;
  logic   is_lru;
  logic   sel_hit;
  logic   sel_free;
  carry_t carry_next;

  assign match    = valid && (key == upd.key);
  assign is_lru   = valid && (rank == '0);
  assign sel_hit  = match && !carry_in.found;
  assign sel_free = !valid && !carry_in.free_seen;

  always_comb begin
    carry_next = carry_in;
    if (!carry_in.found && match) begin
      carry_next.found        = 1'b1;
      carry_next.found_handle = handle;
    end
    if (!carry_in.lru_found && is_lru) begin
      carry_next.lru_found  = 1'b1;
      carry_next.lru_key    = key;
      carry_next.lru_handle = handle;
    end
    carry_next.free_seen = carry_in.free_seen || !valid;
  end

  always_ff @(posedge clk) begin
    carry_out <= carry_next;
    rank_out  <= carry_in.found ? rank_in : rank;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      rank  <= '0;
    end else begin
      unique case (upd.op)
        OP_PROMOTE, OP_PROMOTE_SET: begin
          if (sel_hit) begin
            rank <= new_rank;
          end else if (valid && (rank > pivot_rank)) begin
            rank <= rank - 1'b1;
          end
        end
        OP_EVICT: begin
          if (is_lru) begin
            rank <= new_rank;
          end else if (valid) begin
            rank <= rank - 1'b1;
          end
        end
        OP_FILL: begin
          if (sel_free) begin
            valid <= 1'b1;
            rank  <= new_rank;
          end
        end
        OP_CLEAR: begin
          valid <= 1'b0;
          rank  <= '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if ((upd.op == OP_PROMOTE_SET) && sel_hit) begin
      handle <= upd.handle;
    end else if ((upd.op == OP_EVICT && is_lru) || (upd.op == OP_FILL && sel_free)) begin
      key    <= upd.key;
      handle <= upd.handle;
    end
  end

endmodule

[rtl/ldc_ctrl.sv]
// ----------------------------------------------------------------------------
// LRU descriptor cache control
// Sequences the search wave and the update, keeps the entry count and
// registers the result.
// ----------------------------------------------------------------------------
module ldc_ctrl
  import ldc_pkg::*;
#(
  parameter int CAPACITY = DEFAULT_CAPACITY,
  parameter int RANK_W   = $clog2(CAPACITY),
  parameter int COUNT_W  = $clog2(CAPACITY + 1)
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [CMD_W-1:0]       command,
  input  logic [KEY_W-1:0]       key,
  input  logic [HANDLE_W-1:0]    handle,
  output logic                   busy,
  output logic                   done,
  output logic                   hit,
  output logic [HANDLE_W-1:0]    found_handle,
  output logic                   evicted,
  output logic [KEY_W-1:0]       evicted_key,
  output logic [HANDLE_W-1:0]    evicted_handle,
  output logic [COUNT_OUT_W-1:0] entry_count,
  input  carry_t                 tail,
  input  logic [RANK_W-1:0]      tail_rank,
  output upd_t                   upd,
  output logic [RANK_W-1:0]      pivot_rank,
  output logic [RANK_W-1:0]      new_rank
);

  state_t              state;
  state_t              state_next;
  logic [RANK_W-1:0]   cnt;
  logic [COUNT_W-1:0]  count;
  logic [COUNT_W-1:0]  count_next;
  cmd_t                cmd_q;
  logic [KEY_W-1:0]    key_q;
  logic [HANDLE_W-1:0] handle_q;
  op_t                 op;
  logic                full;

  assign full = (count == COUNT_W'(CAPACITY));
  assign busy = (state != ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
      count <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= (state == ST_SCAN) ? cnt + 1'b1 : '0;
      count <= count_next;
      done  <= (state == ST_UPDATE);
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      cmd_q    <= cmd_t'(command);
      key_q    <= key;
      handle_q <= handle;
    end
  end

  always_comb begin
    state_next = state;
    op         = OP_NONE;
    count_next = count;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (cnt == RANK_W'(CAPACITY - 1)) begin
          state_next = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        state_next = ST_IDLE;
        unique case (cmd_q)
          CMD_LOOKUP: op = tail.found ? OP_PROMOTE : OP_NONE;
          CMD_INSERT: begin
            if (tail.found) begin
              op = OP_PROMOTE_SET;
            end else if (full) begin
              op = OP_EVICT;
            end else begin
              op = OP_FILL;
            end
          end
          CMD_CLEAR:  op = OP_CLEAR;
          CMD_NOP:    op = OP_NONE;
          default:    op = OP_NONE;
        endcase
        if (op == OP_CLEAR) begin
          count_next = '0;
        end else if (op == OP_FILL) begin
          count_next = count + 1'b1;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign upd.op     = op;
  assign upd.key    = key_q;
  assign upd.handle = handle_q;
  assign pivot_rank = (op == OP_EVICT) ? '0 : tail_rank;
  assign new_rank   = (op == OP_FILL) ? RANK_W'(count) : RANK_W'(count - 1'b1);

  always_ff @(posedge clk) begin
    if (state == ST_UPDATE) begin
      hit            <= (op == OP_PROMOTE) || (op == OP_PROMOTE_SET);
      found_handle   <= ((op == OP_PROMOTE) || (op == OP_PROMOTE_SET)) ?
                        tail.found_handle : '0;
      evicted        <= (op == OP_EVICT);
      evicted_key    <= (op == OP_EVICT) ? tail.lru_key : '0;
      evicted_handle <= (op == OP_EVICT) ? tail.lru_handle : '0;
      entry_count    <= COUNT_OUT_W'(count_next);
    end
  end

endmodule

[rtl/lru_descriptor_cache_core.sv]
// ----------------------------------------------------------------------------
// LRU descriptor cache core
// Fully associative table of descriptor keys and record handles kept in
// recency order, built as a chain of entry cells.
// ----------------------------------------------------------------------------
// A transaction is accepted at a rising edge with start high and busy low;
// command selects lookup, insert or clear, with key and handle alongside.
// A search record walks down the chain of CAPACITY cells, one cell per
// cycle, collecting the matching entry, the least recent entry and whether
// a free slot exists. The update is then applied to all cells together.
// The result is on the result ports with done high for exactly one cycle,
// after the update; busy falls in that same cycle, so a new transaction is
// taken only once the current one has finished. The length of the cell
// chain sets the duration of the search. Every result carries the entry
// count after the operation. An insert of a new key into a full table
// evicts the least recent entry and reports its key and handle.
// Reset empties the table at once and clears the count; no sweep is needed.
// The receiver cannot stall and must take each result when done is high.
// ----------------------------------------------------------------------------
module lru_descriptor_cache_core
  import ldc_pkg::*;
#(
  parameter int CAPACITY = DEFAULT_CAPACITY
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  output logic                   busy,
  input  logic [CMD_W-1:0]       command,
  input  logic [KEY_W-1:0]       key,
  input  logic [HANDLE_W-1:0]    handle,
  output logic                   done,
  output logic                   hit,
  output logic [HANDLE_W-1:0]    found_handle,
  output logic                   evicted,
  output logic [KEY_W-1:0]       evicted_key,
  output logic [HANDLE_W-1:0]    evicted_handle,
  output logic [COUNT_OUT_W-1:0] entry_count
);

  localparam int RANK_W  = $clog2(CAPACITY);
  localparam int COUNT_W = $clog2(CAPACITY + 1);

  carry_t            carry [CAPACITY+1];
  logic [RANK_W-1:0] rank  [CAPACITY+1];
  upd_t              upd;
  logic [RANK_W-1:0] pivot_rank;
  logic [RANK_W-1:0] new_rank;

  assign carry[0] = '0;
  assign rank[0]  = '0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    ldc_cell #(
      .RANK_W(RANK_W)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .upd       (upd),
      .pivot_rank(pivot_rank),
      .new_rank  (new_rank),
      .carry_in  (carry[i]),
      .rank_in   (rank[i]),
      .carry_out (carry[i+1]),
      .rank_out  (rank[i+1])
    );
  end

  ldc_ctrl #(
    .CAPACITY(CAPACITY),
    .RANK_W  (RANK_W),
    .COUNT_W (COUNT_W)
  ) u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .command       (command),
    .key           (key),
    .handle        (handle),
    .busy          (busy),
    .done          (done),
    .hit           (hit),
    .found_handle  (found_handle),
    .evicted       (evicted),
    .evicted_key   (evicted_key),
    .evicted_handle(evicted_handle),
    .entry_count   (entry_count),
    .tail          (carry[CAPACITY]),
    .tail_rank     (rank[CAPACITY]),
    .upd           (upd),
    .pivot_rank    (pivot_rank),
    .new_rank      (new_rank)
  );

endmodule

[verif/tb_lru_descriptor_cache_core.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for the LRU descriptor cache core
// A short directed sequence and random bursts of lookup, insert, clear and
// no-op transactions are sent through the start/busy handshake. A shadow
// table in the bench tracks keys, handles and recency, and each result
// strobed by done is checked field by field against its prediction.
// ----------------------------------------------------------------------------
module tb_lru_descriptor_cache_core;
  import ldc_pkg::*;

  localparam int CAPACITY = DEFAULT_CAPACITY;
  localparam int RANDOM_OPS = 950;
  localparam int POOL_SIZE = 160;
  localparam int CYCLE_LIMIT = 600000;
  localparam int MAX_PRINTED = 20;

  typedef struct packed {
    cmd_t                cmd;
    logic [KEY_W-1:0]    key;
    logic [HANDLE_W-1:0] hnd;
    logic [4:0]          gap;
  } cache_op_t;

  typedef struct packed {
    logic                   hit;
    logic [HANDLE_W-1:0]    found_handle;
    logic                   evicted;
    logic [KEY_W-1:0]       evicted_key;
    logic [HANDLE_W-1:0]    evicted_handle;
    logic [COUNT_OUT_W-1:0] entry_count;
  } cache_rsp_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   start = 1'b0;
  logic [CMD_W-1:0]       command = CMD_NOP;
  logic [KEY_W-1:0]       key = '0;
  logic [HANDLE_W-1:0]    handle = '0;
  logic                   busy;
  logic                   done;
  logic                   hit;
  logic [HANDLE_W-1:0]    found_handle;
  logic                   evicted;
  logic [KEY_W-1:0]       evicted_key;
  logic [HANDLE_W-1:0]    evicted_handle;
  logic [COUNT_OUT_W-1:0] entry_count;

  lru_descriptor_cache_core #(
    .CAPACITY(CAPACITY)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .command(command),
    .key(key),
    .handle(handle),
    .done(done),
    .hit(hit),
    .found_handle(found_handle),
    .evicted(evicted),
    .evicted_key(evicted_key),
    .evicted_handle(evicted_handle),
    .entry_count(entry_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow copy of the table.
  logic [KEY_W-1:0]    shadow_key[CAPACITY];
  logic [HANDLE_W-1:0] shadow_handle[CAPACITY];
  bit                  shadow_valid[CAPACITY];
  int                  shadow_rank[CAPACITY];
  int                  shadow_count = 0;

  cache_op_t  queued_ops[$];
  cache_rsp_t awaited_results[$];
  int         mismatches = 0;
  int         ops_sent = 0;
  int         results_seen = 0;
  int         hits_seen = 0;
  int         evictions_seen = 0;
  int         clears_sent = 0;
  int         cycles = 0;

  // The entry in slot s becomes the most recent one.
  function automatic void make_newest(input int s);
    int old_rank;
    old_rank = shadow_rank[s];
    for (int i = 0; i < CAPACITY; i++) begin
      if (shadow_valid[i] && shadow_rank[i] > old_rank) shadow_rank[i]--;
    end
    shadow_rank[s] = shadow_count - 1;
  endfunction

  function automatic cache_rsp_t update_shadow_table(input cache_op_t op);
    cache_rsp_t r;
    int slot;
    int spot;
    r = '0;
    slot = -1;
    for (int i = 0; i < CAPACITY; i++) begin
      if (slot < 0 && shadow_valid[i] && shadow_key[i] == op.key) slot = i;
    end
    case (op.cmd)
      CMD_LOOKUP: begin
        if (slot >= 0) begin
          r.hit = 1'b1;
          r.found_handle = shadow_handle[slot];
          make_newest(slot);
        end
      end
      CMD_INSERT: begin
        if (slot >= 0) begin
          r.hit = 1'b1;
          r.found_handle = shadow_handle[slot];
          shadow_handle[slot] = op.hnd;
          make_newest(slot);
        end else if (shadow_count >= CAPACITY) begin
          spot = -1;
          for (int i = 0; i < CAPACITY; i++) begin
            if (spot < 0 && shadow_valid[i] && shadow_rank[i] == 0) spot = i;
          end
          if (spot < 0) spot = 0;
          r.evicted = 1'b1;
          r.evicted_key = shadow_key[spot];
          r.evicted_handle = shadow_handle[spot];
          shadow_key[spot] = op.key;
          shadow_handle[spot] = op.hnd;
          make_newest(spot);
        end else begin
          spot = -1;
          for (int i = 0; i < CAPACITY; i++) begin
            if (spot < 0 && !shadow_valid[i]) spot = i;
          end
          if (spot >= 0) begin
            shadow_valid[spot] = 1'b1;
            shadow_key[spot] = op.key;
            shadow_handle[spot] = op.hnd;
            shadow_rank[spot] = shadow_count;
            shadow_count++;
          end
        end
      end
      CMD_CLEAR: begin
        for (int i = 0; i < CAPACITY; i++) begin
          shadow_valid[i] = 1'b0;
          shadow_rank[i] = 0;
        end
        shadow_count = 0;
      end
      default: ;
    endcase
    r.entry_count = shadow_count[COUNT_OUT_W-1:0];
    return r;
  endfunction

  task automatic report_mismatch(input string what);
    if (mismatches < MAX_PRINTED) $display("[%0t] mismatch: %s", $time, what);
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("result %0d %s: got 0x%0h, expected 0x%0h",
                                results_seen, name, got, want));
    end
  endtask

  task automatic queue_op(input cmd_t cmd, input logic [KEY_W-1:0] k,
                          input logic [HANDLE_W-1:0] h, input int gap);
    cache_op_t op;
    op.cmd = cmd;
    op.key = k;
    op.hnd = h;
    op.gap = gap[4:0];
    queued_ops.push_back(op);
  endtask

  // Driver: the wait drawn for each transaction counts only cycles in
  // which the block is idle, so a zero wait keeps start high while busy.
  cache_op_t cur_op;
  bit        holding = 1'b0;
  int        idle_left = 0;

  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) begin
        awaited_results.push_back(update_shadow_table(cur_op));
        ops_sent++;
        if (cur_op.cmd == CMD_CLEAR) clears_sent++;
        holding = 1'b0;
      end
      if (!holding && queued_ops.size() > 0) begin
        cur_op = queued_ops.pop_front();
        holding = 1'b1;
        idle_left = cur_op.gap;
      end
      if (holding && idle_left > 0 && !busy) idle_left--;
      if (holding && idle_left == 0) begin
        start <= 1'b1;
        command <= cur_op.cmd;
        key <= cur_op.key;
        handle <= cur_op.hnd;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor.
  cache_rsp_t want;

  always @(posedge clk) begin
    if (!rst && done) begin
      if (awaited_results.size() == 0) begin
        report_mismatch("result strobed with no transaction outstanding");
      end else begin
        want = awaited_results.pop_front();
        check_field("hit", 32'(hit), 32'(want.hit));
        check_field("found_handle", 32'(found_handle), 32'(want.found_handle));
        check_field("evicted", 32'(evicted), 32'(want.evicted));
        check_field("evicted_key", 32'(evicted_key), 32'(want.evicted_key));
        check_field("evicted_handle", 32'(evicted_handle), 32'(want.evicted_handle));
        check_field("entry_count", 32'(entry_count), 32'(want.entry_count));
        if (want.hit) hits_seen++;
        if (want.evicted) evictions_seen++;
        results_seen++;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding.", cycles,
               awaited_results.size());
      $display("** lru_descriptor_cache_core: FAILED **");
      $finish;
    end
  end

  initial begin
    logic [KEY_W-1:0]    key_pool[POOL_SIZE];
    logic [HANDLE_W-1:0] h;
    logic [KEY_W-1:0]    k;
    cmd_t                cmd;
    int                  counted;
    int                  burst_len;
    int                  span;
    int                  insert_pct;
    int                  roll;
    bit                  no_idle;

    for (int i = 0; i < CAPACITY; i++) begin
      shadow_key[i] = '0;
      shadow_handle[i] = '0;
      shadow_valid[i] = 1'b0;
      shadow_rank[i] = 0;
    end

    queue_op(CMD_LOOKUP, '0, '0, $urandom_range(0, 19));
    queue_op(CMD_NOP, '1, '1, $urandom_range(0, 19));
    queue_op(CMD_INSERT, '0, '0, $urandom_range(0, 19));
    queue_op(CMD_INSERT, '1, '1, 0);
    queue_op(CMD_LOOKUP, '1, '0, 0);
    queue_op(CMD_LOOKUP, '0, '1, $urandom_range(0, 19));
    queue_op(CMD_INSERT, '0, 16'hA5A5, $urandom_range(0, 19));
    queue_op(CMD_LOOKUP, '0, '0, 0);
    queue_op(CMD_LOOKUP, 31'h5555_5555, '0, $urandom_range(0, 19));
    queue_op(CMD_INSERT, 31'h2AAA_AAAA, 16'h5A5A, 0);
    queue_op(CMD_INSERT, 31'h5555_5555, 16'hFFFF, 0);
    queue_op(CMD_LOOKUP, '0, '0, 0);
    queue_op(CMD_NOP, '0, '0, $urandom_range(0, 19));
    queue_op(CMD_INSERT, '1, 16'h0001, 0);
    queue_op(CMD_CLEAR, 31'h1234_5678, 16'hBEEF, $urandom_range(0, 19));
    queue_op(CMD_LOOKUP, '1, '0, 0);
    queue_op(CMD_INSERT, 31'h0000_0001, 16'h8000, 0);
    queue_op(CMD_CLEAR, '0, '0, 0);
    queue_op(CMD_CLEAR, '0, '0, $urandom_range(0, 19));

    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int i = 2; i < POOL_SIZE; i++) key_pool[i] = KEY_W'($urandom);

    // Bursts differ in how many distinct keys they touch and how heavily
    // they insert, so the table moves between sparse, full and thrashing.
    counted = 0;
    while (counted < RANDOM_OPS) begin
      burst_len = $urandom_range(40, 120);
      case ($urandom_range(0, 3))
        0: span = 4;
        1: span = 32;
        2: span = 72;
        default: span = POOL_SIZE;
      endcase
      insert_pct = $urandom_range(30, 80);
      no_idle = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 3) == 0) begin
        queue_op(CMD_CLEAR, KEY_W'($urandom), HANDLE_W'($urandom),
                 no_idle ? 0 : $urandom_range(0, 19));
        counted++;
      end
      for (int n = 0; n < burst_len; n++) begin
        roll = $urandom_range(0, 99);
        if (roll < 1) cmd = CMD_CLEAR;
        else if (roll < 3) cmd = CMD_NOP;
        else if (roll < 3 + insert_pct) cmd = CMD_INSERT;
        else cmd = CMD_LOOKUP;
        if ($urandom_range(0, 19) == 0) k = KEY_W'($urandom);
        else k = key_pool[$urandom_range(0, span - 1)];
        case ($urandom_range(0, 19))
          0: h = '0;
          1: h = '1;
          default: h = HANDLE_W'($urandom_range(0, 65535));
        endcase
        queue_op(cmd, k, h, no_idle ? 0 : $urandom_range(0, 19));
        if (cmd != CMD_NOP) counted++;
      end
    end

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    while (queued_ops.size() != 0 || holding || awaited_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (CAPACITY + 8) @(posedge clk);

    $display("Sent %0d transactions (%0d clears) and checked %0d results.",
             ops_sent, clears_sent, results_seen);
    $display("Results included %0d hits and %0d evictions; %0d mismatches.",
             hits_seen, evictions_seen, mismatches);
    if (mismatches == 0 && awaited_results.size() == 0) begin
      $display("** lru_descriptor_cache_core: PASSED **");
    end else begin
      $display("** lru_descriptor_cache_core: FAILED **");
    end
    $finish;
  end

endmodule
